FILE: hw/rtl/crc16_frame_receiver_assert.svh
`ifndef CRC16_FRAME_RECEIVER_ASSERT_SVH
`define CRC16_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled at the rising clock edge, off while rst is true.
`define CRCFR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off while rst is true.
`define CRCFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/crcfr_pkg.sv
package crcfr_pkg;

  // Byte counter width; it must hold BUF_BYTES itself.
  localparam int CNT_W = 9;
  localparam int BUF_BYTES = 64;

  // Frame layout constants.
  localparam logic [7:0] START_BYTE = 8'd16;
  localparam logic [7:0] END_BYTE = 8'd2;
  localparam logic [7:0] MIN_FRAME = 8'd13;
  localparam logic [CNT_W-1:0] PAYLOAD_POS = CNT_W'(10);

  // CRC-16, reflected form.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Event codes.
  localparam logic [2:0] EV_CHANGED = 3'd0;
  localparam logic [2:0] EV_BAD_START = 3'd1;
  localparam logic [2:0] EV_BAD_CRC = 3'd2;
  localparam logic [2:0] EV_EMPTY = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;
  localparam logic [2:0] EV_BAD_LENGTH = 3'd5;

  // Result of processing one byte.
  typedef struct packed {
    logic       hit;
    logic [2:0] code;
    logic [7:0] state;
  } res_t;

  // One byte through the reflected CRC, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/crc16_frame_receiver.sv
// Byte-stream frame receiver with CRC-16 check (reflected 0xA001, init 0xFFFF).
// Input channel: one received byte per transfer on in_tdata[7:0].
// Output channel: at most one event per byte; out_tuser carries the event code
// (0 state changed, 1 bad start, 2 bad CRC, 3 empty payload, 4 overflow,
// 5 bad length) and out_tdata carries the new state byte for code 0, else 0.
// Frame: start byte 16 at position 0, length L at position 2, the CRC over the
// first L-3 bytes at positions L-3 (high) and L-2 (low), payload from 10 on;
// a byte 2 at count 13 or more triggers the check.
// A taken byte waits in the input register, is then processed into the
// result register, and its event is presented to the output from there.
// Throughput is one byte per cycle while the output is not stalled, set by
// the combinational CRC byte update and frame compare between both registers.
// Reset clears the pipeline and the receiver state (count 0, CRC 0xFFFF).
// When the output is stalled, one byte waits in the input register and
// in_tready drops until the pending event is taken.
module crc16_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] relay_state
  output logic [2:0] out_tuser   // [2:0] event_code
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_code_r;
  logic [7:0] out_state_r;
  logic       advance;
  logic       in_xfer;
  crcfr_pkg::res_t res;

  // The input byte is processed once the result register is free.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  crcfr_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  // Valid flags of the input and result registers.
  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = res.hit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
    end
    if (advance) begin
      out_code_r  <= res.code;
      out_state_r <= res.state;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_state_r;
  assign out_tuser  = out_code_r;

endmodule

FILE: hw/rtl/crcfr_frame.sv
module crcfr_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output crcfr_pkg::res_t  res
);

  logic [crcfr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] snap_r, snap_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [7:0]  pay_r, pay_nxt;
  logic [7:0]  last_r, last_nxt;

  logic [crcfr_pkg::CNT_W-1:0] pos;
  logic [crcfr_pkg::CNT_W-1:0] cnt_inc;
  logic [crcfr_pkg::CNT_W-1:0] len_m3;
  logic [crcfr_pkg::CNT_W-1:0] len_m2;
  logic [crcfr_pkg::CNT_W-1:0] len_ext;
  logic [15:0] crc_upd;
  logic        end_hit;
  logic        restart;

  assign pos     = count_r;
  assign cnt_inc = pos + crcfr_pkg::CNT_W'(1);
  assign crc_upd = crcfr_pkg::crc_byte(crc_r, rx_byte);

  // Field captures at their positions within the frame (CRC bytes by the length).
  always_comb begin
    first_nxt = (pos == '0) ? rx_byte : first_r;
    len_nxt   = (pos == crcfr_pkg::CNT_W'(2)) ? rx_byte : len_r;
    pay_nxt   = (pos == crcfr_pkg::PAYLOAD_POS) ? rx_byte : pay_r;
    len_ext   = {1'b0, len_nxt};
    len_m3    = len_ext - crcfr_pkg::CNT_W'(3);
    len_m2    = len_ext - crcfr_pkg::CNT_W'(2);
    rcrc_nxt  = rcrc_r;
    if (len_nxt >= 8'd3 && pos == len_m3) begin
      rcrc_nxt[15:8] = rx_byte;
    end
    if (len_nxt >= 8'd2 && pos == len_m2) begin
      rcrc_nxt[7:0] = rx_byte;
    end
    snap_nxt = (len_nxt >= 8'd3 && cnt_inc == len_m3) ? crc_upd : snap_r;
  end

  // Frame checks, in priority order, on the end byte or on overflow.
  always_comb begin
    end_hit   = (cnt_inc >= crcfr_pkg::CNT_W'(crcfr_pkg::MIN_FRAME)) &&
                (rx_byte == crcfr_pkg::END_BYTE);
    restart   = 1'b0;
    last_nxt  = last_r;
    res.hit   = 1'b0;
    res.code  = crcfr_pkg::EV_CHANGED;
    res.state = 8'h00;
    priority if (end_hit && first_nxt != crcfr_pkg::START_BYTE) begin
      res.hit  = 1'b1;
      res.code = crcfr_pkg::EV_BAD_START;
    end else if (end_hit && len_nxt < crcfr_pkg::MIN_FRAME) begin
      res.hit  = 1'b1;
      res.code = crcfr_pkg::EV_BAD_LENGTH;
    end else if (end_hit && cnt_inc >= len_ext) begin
      restart = 1'b1;
      priority if (rcrc_nxt != snap_nxt) begin
        res.hit  = 1'b1;
        res.code = crcfr_pkg::EV_BAD_CRC;
      end else if (len_nxt == crcfr_pkg::MIN_FRAME) begin
        res.hit  = 1'b1;
        res.code = crcfr_pkg::EV_EMPTY;
      end else if (pay_nxt != last_r) begin
        res.hit   = 1'b1;
        res.code  = crcfr_pkg::EV_CHANGED;
        res.state = pay_nxt;
        last_nxt  = pay_nxt;
      end else begin
        restart = 1'b1;
      end
    end else if (cnt_inc >= crcfr_pkg::CNT_W'(crcfr_pkg::BUF_BYTES)) begin
      res.hit  = 1'b1;
      res.code = crcfr_pkg::EV_OVERFLOW;
    end else begin
      restart = 1'b0;
    end
    if (res.hit || restart) begin
      count_nxt = '0;
      crc_nxt   = crcfr_pkg::CRC_INIT;
    end else begin
      count_nxt = cnt_inc;
      crc_nxt   = crc_upd;
    end
  end

  // Receiver state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      first_r <= 8'h00;
      len_r   <= 8'h00;
      crc_r   <= crcfr_pkg::CRC_INIT;
      snap_r  <= 16'h0000;
      rcrc_r  <= 16'h0000;
      pay_r   <= 8'h00;
      last_r  <= 8'h00;
    end else if (step) begin
      count_r <= count_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      snap_r  <= snap_nxt;
      rcrc_r  <= rcrc_nxt;
      pay_r   <= pay_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

FILE: hw/rtl/crcfr_checker.sv
`include "crc16_frame_receiver_assert.svh"

module crcfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser
);

  // A stalled event holds its contents.
  `CRCFR_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled event changed")

  // Only a state change carries a state byte.
  `CRCFR_ASSERT_NOW(a_state_zero, clk, !rst_n, out_tvalid && out_tuser != crcfr_pkg::EV_CHANGED, out_tdata == 8'h00, "state byte on an error event")

  // The input side only stalls behind a stalled output.
  `CRCFR_ASSERT_NOW(a_stall_cause, clk, !rst_n, !in_tready, out_tvalid && !out_tready, "input stalled without output backpressure")

  // Reset empties the result register.
  `CRCFR_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_tvalid, "event presented after reset")

endmodule

bind crc16_frame_receiver crcfr_checker u_crcfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
